[rtl/core/cldd_pkg.sv]
// Shared types for the circular list: request and result items, microcode
// word layout, status flags and the control-store program.
// No dependencies.
package cldd_pkg;

    typedef enum logic [1:0] {
        OP_INS_END   = 2'd0,
        OP_INS_FRONT = 2'd1,
        OP_DELETE    = 2'd2,
        OP_DISPLAY   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_op                operation;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] data;
        logic               last;
    } t_out_item;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] t_upc;

    typedef enum logic [3:0] {
        ACT_NOP,
        ACT_ACCEPT,
        ACT_INSERT,
        ACT_READ,
        ACT_READ_NEXT,
        ACT_POS_INC,
        ACT_SHIFT,
        ACT_HEAD_INC,
        ACT_CNT_DEC,
        ACT_EMIT_DATA,
        ACT_EMIT_OK,
        ACT_EMIT_FULL,
        ACT_EMIT_EMPTY,
        ACT_EMIT_NF
    } t_act;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_OP_DEL,
        C_OP_DISP,
        C_FULL,
        C_EMPTY,
        C_POS_END,
        C_MATCH,
        C_POS_ZERO,
        C_LAST
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        logic  wait_out;
        t_upc  target;
    } t_uword;

    typedef struct packed {
        logic no_in;
        logic op_del;
        logic op_disp;
        logic full;
        logic empty;
        logic pos_end;
        logic match;
        logic pos_zero;
        logic last;
        logic out_busy;
    } t_flags;

    localparam t_upc U_IDLE      = 5'd0;
    localparam t_upc U_CHK_DEL   = 5'd1;
    localparam t_upc U_CHK_DISP  = 5'd2;
    localparam t_upc U_CHK_FULL  = 5'd3;
    localparam t_upc U_INSERT    = 5'd4;
    localparam t_upc U_DEL_CHK   = 5'd5;
    localparam t_upc U_SRCH_RD   = 5'd6;
    localparam t_upc U_SRCH_CMP  = 5'd7;
    localparam t_upc U_SRCH_NXT  = 5'd8;
    localparam t_upc U_FOUND     = 5'd9;
    localparam t_upc U_SHIFT_RD  = 5'd10;
    localparam t_upc U_SHIFT_WR  = 5'd11;
    localparam t_upc U_DROP_HEAD = 5'd12;
    localparam t_upc U_DROP_TAIL = 5'd13;
    localparam t_upc U_DISP_CHK  = 5'd14;
    localparam t_upc U_DISP_RD   = 5'd15;
    localparam t_upc U_DISP_EMIT = 5'd16;
    localparam t_upc U_DISP_NXT  = 5'd17;
    localparam t_upc U_EM_OK     = 5'd18;
    localparam t_upc U_EM_FULL   = 5'd19;
    localparam t_upc U_EM_EMPTY  = 5'd20;
    localparam t_upc U_EM_NF     = 5'd21;

    function automatic t_uword uc_rom(input t_upc pc);
        t_uword w;
        w = '{act: ACT_NOP, cond: C_ALWAYS, wait_out: 1'b0, target: U_IDLE};
        case (pc)
            U_IDLE:      w = '{ACT_ACCEPT,     C_NO_IN,    1'b0, U_IDLE};
            U_CHK_DEL:   w = '{ACT_NOP,        C_OP_DEL,   1'b0, U_DEL_CHK};
            U_CHK_DISP:  w = '{ACT_NOP,        C_OP_DISP,  1'b0, U_DISP_CHK};
            U_CHK_FULL:  w = '{ACT_NOP,        C_FULL,     1'b0, U_EM_FULL};
            U_INSERT:    w = '{ACT_INSERT,     C_ALWAYS,   1'b0, U_EM_OK};
            U_DEL_CHK:   w = '{ACT_NOP,        C_EMPTY,    1'b0, U_EM_EMPTY};
            U_SRCH_RD:   w = '{ACT_READ,       C_POS_END,  1'b0, U_EM_NF};
            U_SRCH_CMP:  w = '{ACT_NOP,        C_MATCH,    1'b0, U_FOUND};
            U_SRCH_NXT:  w = '{ACT_POS_INC,    C_ALWAYS,   1'b0, U_SRCH_RD};
            U_FOUND:     w = '{ACT_NOP,        C_POS_ZERO, 1'b0, U_DROP_HEAD};
            U_SHIFT_RD:  w = '{ACT_READ_NEXT,  C_LAST,     1'b0, U_DROP_TAIL};
            U_SHIFT_WR:  w = '{ACT_SHIFT,      C_ALWAYS,   1'b0, U_SHIFT_RD};
            U_DROP_HEAD: w = '{ACT_HEAD_INC,   C_ALWAYS,   1'b0, U_EM_OK};
            U_DROP_TAIL: w = '{ACT_CNT_DEC,    C_ALWAYS,   1'b0, U_EM_OK};
            U_DISP_CHK:  w = '{ACT_NOP,        C_EMPTY,    1'b0, U_EM_EMPTY};
            U_DISP_RD:   w = '{ACT_READ,       C_NEVER,    1'b0, U_IDLE};
            U_DISP_EMIT: w = '{ACT_EMIT_DATA,  C_LAST,     1'b1, U_IDLE};
            U_DISP_NXT:  w = '{ACT_NOP,        C_ALWAYS,   1'b0, U_DISP_RD};
            U_EM_OK:     w = '{ACT_EMIT_OK,    C_ALWAYS,   1'b1, U_IDLE};
            U_EM_FULL:   w = '{ACT_EMIT_FULL,  C_ALWAYS,   1'b1, U_IDLE};
            U_EM_EMPTY:  w = '{ACT_EMIT_EMPTY, C_ALWAYS,   1'b1, U_IDLE};
            U_EM_NF:     w = '{ACT_EMIT_NF,    C_ALWAYS,   1'b1, U_IDLE};
            default:     w = '{ACT_NOP,        C_ALWAYS,   1'b0, U_IDLE};
        endcase
        return w;
    endfunction

endpackage

[rtl/core/cldd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cldd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/cldd_useq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on cldd_pkg.
module cldd_useq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cldd_pkg::t_flags  i_flags,
    output cldd_pkg::t_uword  o_uword
);
    import cldd_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword w_uword;
    logic   w_take;

    assign w_uword = uc_rom(r_upc);
    assign o_uword = w_uword;

    always_comb begin
        case (w_uword.cond)
            C_NEVER:    w_take = 1'b0;
            C_ALWAYS:   w_take = 1'b1;
            C_NO_IN:    w_take = i_flags.no_in;
            C_OP_DEL:   w_take = i_flags.op_del;
            C_OP_DISP:  w_take = i_flags.op_disp;
            C_FULL:     w_take = i_flags.full;
            C_EMPTY:    w_take = i_flags.empty;
            C_POS_END:  w_take = i_flags.pos_end;
            C_MATCH:    w_take = i_flags.match;
            C_POS_ZERO: w_take = i_flags.pos_zero;
            C_LAST:     w_take = i_flags.last;
            default:    w_take = 1'b0;
        endcase
    end

    always_comb begin
        if (w_uword.wait_out && i_flags.out_busy) begin
            n_upc = r_upc;
        end else if (w_take) begin
            n_upc = w_uword.target;
        end else begin
            n_upc = r_upc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

[rtl/core/cldd_dpath.sv]
// Datapath: request latch, head and count registers, ring index math, entry
// RAM and the result register. Depends on cldd_pkg and cldd_ram.
module cldd_dpath #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cldd_pkg::t_uword     i_uword,
    output cldd_pkg::t_flags     o_flags,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cldd_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cldd_pkg::t_out_item  o_out_item
);
    import cldd_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] CAP_S = SUM_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] CAP_LAST = IDX_W'(CAPACITY - 1);

    t_op                r_op;
    logic [31:0]        r_value;
    logic [IDX_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_pos;
    logic               r_out_valid;
    t_out_item          r_out_item;

    logic [SUM_W-1:0]   w_head_ext;
    logic [SUM_W-1:0]   w_sum_pos;
    logic [SUM_W-1:0]   w_sum_nxt;
    logic [SUM_W-1:0]   w_sum_end;
    logic [IDX_W-1:0]   w_slot_pos;
    logic [IDX_W-1:0]   w_slot_nxt;
    logic [IDX_W-1:0]   w_slot_end;
    logic [IDX_W-1:0]   w_head_prev;
    logic [IDX_W-1:0]   w_head_next;
    logic [SUM_W-1:0]   w_pos_plus;
    logic               w_accept;
    logic               w_out_busy;
    logic               w_emit;
    logic               w_we;
    logic [IDX_W-1:0]   w_waddr;
    logic [31:0]        w_wdata;
    logic               w_re;
    logic [IDX_W-1:0]   w_raddr;
    logic [31:0]        w_rdata;
    t_out_item          w_item;

    assign w_head_ext = SUM_W'(r_head);
    assign w_sum_pos  = w_head_ext + SUM_W'(r_pos);
    assign w_sum_nxt  = w_sum_pos + 1'b1;
    assign w_sum_end  = w_head_ext + SUM_W'(r_count);
    assign w_slot_pos = (w_sum_pos >= CAP_S) ? IDX_W'(w_sum_pos - CAP_S) : IDX_W'(w_sum_pos);
    assign w_slot_nxt = (w_sum_nxt >= CAP_S) ? IDX_W'(w_sum_nxt - CAP_S) : IDX_W'(w_sum_nxt);
    assign w_slot_end = (w_sum_end >= CAP_S) ? IDX_W'(w_sum_end - CAP_S) : IDX_W'(w_sum_end);
    assign w_head_prev = (r_head == '0) ? CAP_LAST : r_head - 1'b1;
    assign w_head_next = (r_head == CAP_LAST) ? '0 : r_head + 1'b1;
    assign w_pos_plus  = SUM_W'(r_pos) + 1'b1;

    assign o_in_ready = (i_uword.act == ACT_ACCEPT);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_slot_pos;
        w_wdata = w_rdata;
        w_re    = 1'b0;
        w_raddr = w_slot_pos;
        case (i_uword.act)
            ACT_INSERT: begin
                w_we    = 1'b1;
                w_waddr = (r_op == OP_INS_END) ? w_slot_end : w_head_prev;
                w_wdata = r_value;
            end
            ACT_SHIFT: begin
                w_we = 1'b1;
            end
            ACT_READ: begin
                w_re = 1'b1;
            end
            ACT_READ_NEXT: begin
                w_re    = 1'b1;
                w_raddr = w_slot_nxt;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    cldd_ram #(
        .WIDTH (32),
        .DEPTH (CAPACITY)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_emit = (i_uword.act inside {ACT_EMIT_DATA, ACT_EMIT_OK, ACT_EMIT_FULL,
                                      ACT_EMIT_EMPTY, ACT_EMIT_NF}) && !w_out_busy;
        w_item = '{status: ST_OK, data: 32'sd0, last: 1'b1};
        case (i_uword.act)
            ACT_EMIT_DATA: begin
                w_item.data = signed'(w_rdata);
                w_item.last = (w_pos_plus == SUM_W'(r_count));
            end
            ACT_EMIT_FULL:  w_item.status = ST_FULL;
            ACT_EMIT_EMPTY: w_item.status = ST_EMPTY;
            ACT_EMIT_NF:    w_item.status = ST_NOT_FOUND;
            default:        w_item.status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_uword.act)
                ACT_ACCEPT:  r_pos <= '0;
                ACT_POS_INC: r_pos <= r_pos + 1'b1;
                ACT_SHIFT:   r_pos <= r_pos + 1'b1;
                ACT_INSERT: begin
                    r_count <= r_count + 1'b1;
                    if (r_op != OP_INS_END) begin
                        r_head <= w_head_prev;
                    end
                end
                ACT_HEAD_INC: begin
                    r_head  <= w_head_next;
                    r_count <= r_count - 1'b1;
                end
                ACT_CNT_DEC: r_count <= r_count - 1'b1;
                ACT_EMIT_DATA: begin
                    if (w_emit) begin
                        r_pos <= r_pos + 1'b1;
                    end
                end
                default: r_pos <= r_pos;
            endcase
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_in_item.operation;
            r_value <= i_in_item.value;
        end
        if (w_emit) begin
            r_out_item <= w_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign o_flags = '{
        no_in:    !i_in_valid,
        op_del:   (r_op == OP_DELETE),
        op_disp:  (r_op == OP_DISPLAY),
        full:     (r_count == CAP_C),
        empty:    (r_count == '0),
        pos_end:  (r_pos == r_count),
        match:    (w_rdata == r_value),
        pos_zero: (r_pos == '0),
        last:     (w_pos_plus == SUM_W'(r_count)),
        out_busy: w_out_busy
    };

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.act == ACT_INSERT) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("insert did not grow the list by one");

    a_full_only_at_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uword.act == ACT_EMIT_FULL) |-> (r_count == CAP_C))
        else $error("full status below capacity");

    a_no_emit_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_item))
        else $error("result overwritten while stalled");

endmodule

[rtl/core/circular_list_deque_delete.sv]
// Bounded circular list of signed 32-bit values with insert at end or front,
// delete by value and display. Depends on cldd_pkg, cldd_useq, cldd_dpath.
//
// Usage: one request per transfer on the input channel (operation, value);
// results leave on the output channel as (status, data, last), last marking
// the final result of a request. Both channels use valid/ready.
// Results, with N entries in the list:
//   insert: one result, a full status when the list is full.
//   delete: one result; a match at the head drops the head, a match at
//           position k > 0 shifts later entries down; not found, or empty.
//   display: N results, one per entry in list order; one empty status when empty.
// Each list step costs one pass through the entry RAM, whose registered read
// port is used once per step, plus a sequencer step to test or write back.
// Items are handled one at a time; the result register frees the sequencer
// to take the next request while a result waits to be taken.
// Reset empties the list (head and count cleared); RAM contents are not
// cleared. A stalled receiver holds the sequencer at its next result step.
module circular_list_deque_delete #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cldd_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cldd_pkg::t_out_item  o_out_item
);
    import cldd_pkg::*;

    t_uword w_uword;
    t_flags w_flags;

    cldd_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uword)
    );

    cldd_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uword     (w_uword),
        .o_flags     (w_flags),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
